/* rtl/ltrb_pkg.sv */
`default_nettype none

package ltrb_pkg;

  // store geometry
  localparam int DEPTH  = 4096;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // transaction field widths
  localparam int OFF_W  = 12;
  localparam int POS_W  = 12;
  localparam int FILL_W = 13;
  localparam int BYTE_W = 8;

  // adder and compare widths
  localparam int SUM_W = ((ADDR_W > OFF_W) ? ADDR_W : OFF_W) + 1;
  localparam int CMP_W = (OFF_W > CNT_W) ? OFF_W : CNT_W;

  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [BYTE_W-1:0] char_in;
    logic              last_of_string;
    logic [OFF_W-1:0]  read_offset;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              read_valid;
    logic [POS_W-1:0]  oldest_pos;
    logic [POS_W-1:0]  next_write_pos;
    logic [FILL_W-1:0] fill_count;
  } result_t;

  function automatic logic [ADDR_W-1:0] pos_next(input logic [ADDR_W-1:0] p);
    pos_next = (p == ADDR_W'(DEPTH - 1)) ? '0 : p + ADDR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] pos_prev(input logic [ADDR_W-1:0] p);
    pos_prev = (p == '0) ? ADDR_W'(DEPTH - 1) : p - ADDR_W'(1);
  endfunction

endpackage

`default_nettype wire

/* rtl/ltrb_ram.sv */
`default_nettype none

module ltrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/line_evicting_text_ring_buffer.sv */
`default_nettype none

// text ring buffer over a 4096-byte single-write, single-read store. each
// transaction carries one operation: append a character, read the byte at an
// offset from the oldest held byte, or clear. every transaction returns one
// result with the read byte (zero unless valid) and the oldest position, next
// write position and fill count after the operation. an append into a full
// buffer first evicts the oldest line: the oldest byte, then everything up to
// and through the next cr/lf run. a cr inside a string is held pending; a
// following lf stores cr and lf, anything else first backs the write position
// up to just after the last stored lf. eviction and back-up both walk one byte
// at a time through the store's registered read port. a pending result holds
// up only the end of the next transaction, not its acceptance. the store has
// no reset and needs no clearing pass: a byte read from a position that is not
// held is never returned.
module line_evicting_text_ring_buffer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire ltrb_pkg::item_t  item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output ltrb_pkg::result_t     result
);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_APPEND  = 11'b000_0000_0010,
    ST_PROC    = 11'b000_0000_0100,
    ST_BU_RD   = 11'b000_0000_1000,
    ST_BU_CHK  = 11'b000_0001_0000,
    ST_STORE   = 11'b000_0010_0000,
    ST_EV_RD   = 11'b000_0100_0000,
    ST_EV_CHK  = 11'b000_1000_0000,
    ST_RD      = 11'b001_0000_0000,
    ST_RD_WAIT = 11'b010_0000_0000,
    ST_DONE    = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  // buffer state
  logic [ltrb_pkg::ADDR_W-1:0] read_pos, read_pos_next;
  logic [ltrb_pkg::ADDR_W-1:0] write_pos, write_pos_next;
  logic [ltrb_pkg::CNT_W-1:0]  byte_count, byte_count_next;
  logic                        cr_pending, cr_pending_next;

  // transaction in flight
  ltrb_pkg::item_t             cur, cur_next;
  logic [ltrb_pkg::BYTE_W-1:0] st_byte, st_byte_next;   // byte being stored
  logic                        lf_follow, lf_follow_next; // store lf after cr
  logic                        bu_then_proc, bu_then_proc_next;
  logic                        seen_eol, seen_eol_next;
  logic                        rd_ok, rd_ok_next;
  logic [ltrb_pkg::BYTE_W-1:0] rd_byte, rd_byte_next;

  // output register
  logic              result_valid_next;
  ltrb_pkg::result_t result_next;

  // store ports
  logic                        ram_wr_en;
  logic [ltrb_pkg::ADDR_W-1:0] ram_wr_addr;
  logic [ltrb_pkg::BYTE_W-1:0] ram_wr_data;
  logic                        ram_rd_en;
  logic [ltrb_pkg::ADDR_W-1:0] ram_rd_addr;
  logic [ltrb_pkg::BYTE_W-1:0] ram_rd_data;

  // offset read address, wrapped once around the store
  logic [ltrb_pkg::SUM_W-1:0]  rd_sum;
  logic [ltrb_pkg::ADDR_W-1:0] rd_idx;
  logic                        off_in_range;
  logic                        full;
  logic                        empty;
  logic                        ram_eol;

  assign rd_sum = ltrb_pkg::SUM_W'(read_pos) + ltrb_pkg::SUM_W'(cur.read_offset);
  assign rd_idx = (rd_sum >= ltrb_pkg::SUM_W'(ltrb_pkg::DEPTH))
                  ? ltrb_pkg::ADDR_W'(rd_sum - ltrb_pkg::SUM_W'(ltrb_pkg::DEPTH))
                  : ltrb_pkg::ADDR_W'(rd_sum);
  assign off_in_range = ltrb_pkg::CMP_W'(cur.read_offset) < ltrb_pkg::CMP_W'(byte_count);
  assign full    = (byte_count == ltrb_pkg::CNT_W'(ltrb_pkg::DEPTH));
  assign empty   = (byte_count == '0);
  assign ram_eol = (ram_rd_data == ltrb_pkg::CH_CR) || (ram_rd_data == ltrb_pkg::CH_LF);

  assign item_ready = (state == ST_IDLE);

  ltrb_ram #(
    .WIDTH (ltrb_pkg::BYTE_W),
    .DEPTH (ltrb_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_next        = state;
    read_pos_next     = read_pos;
    write_pos_next    = write_pos;
    byte_count_next   = byte_count;
    cr_pending_next   = cr_pending;
    cur_next          = cur;
    st_byte_next      = st_byte;
    lf_follow_next    = lf_follow;
    bu_then_proc_next = bu_then_proc;
    seen_eol_next     = seen_eol;
    rd_ok_next        = rd_ok;
    rd_byte_next      = rd_byte;
    result_valid_next = result_valid;
    result_next       = result;

    ram_wr_en   = 1'b0;
    ram_wr_addr = write_pos;
    ram_wr_data = st_byte;
    ram_rd_en   = 1'b0;
    ram_rd_addr = read_pos;

    // the consumer takes the pending result
    if (result_valid && result_ready) begin
      result_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cur_next   = item;
          rd_ok_next = 1'b0;
          unique case (item.func)
            ltrb_pkg::FUNC_APPEND: state_next = ST_APPEND;
            ltrb_pkg::FUNC_READ:   state_next = ST_RD;
            ltrb_pkg::FUNC_CLEAR: begin
              read_pos_next   = '0;
              write_pos_next  = '0;
              byte_count_next = '0;
              cr_pending_next = 1'b0;
              state_next      = ST_DONE;
            end
            ltrb_pkg::FUNC_NONE:   state_next = ST_DONE;
          endcase
        end
      end

      // resolve a pending cr against this character
      ST_APPEND: begin
        if (cr_pending) begin
          cr_pending_next = 1'b0;
          if (cur.char_in == ltrb_pkg::CH_LF) begin
            st_byte_next   = ltrb_pkg::CH_CR;
            lf_follow_next = 1'b1;
            state_next     = ST_STORE;
          end else begin
            bu_then_proc_next = 1'b1;
            state_next        = ST_BU_RD;
          end
        end else begin
          state_next = ST_PROC;
        end
      end

      ST_PROC: begin
        if (cur.char_in == ltrb_pkg::CH_CR) begin
          if (cur.last_of_string) begin
            bu_then_proc_next = 1'b0;
            state_next        = ST_BU_RD;
          end else begin
            cr_pending_next = 1'b1;
            state_next      = ST_DONE;
          end
        end else begin
          st_byte_next   = cur.char_in;
          lf_follow_next = 1'b0;
          state_next     = ST_STORE;
        end
      end

      // back-up: look at the byte before the write position
      ST_BU_RD: begin
        if (empty) begin
          state_next = bu_then_proc ? ST_PROC : ST_DONE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ltrb_pkg::pos_prev(write_pos);
          state_next  = ST_BU_CHK;
        end
      end

      ST_BU_CHK: begin
        if (ram_rd_data == ltrb_pkg::CH_LF) begin
          state_next = bu_then_proc ? ST_PROC : ST_DONE;
        end else begin
          write_pos_next  = ltrb_pkg::pos_prev(write_pos);
          byte_count_next = byte_count - ltrb_pkg::CNT_W'(1);
          state_next      = ST_BU_RD;
        end
      end

      // store one byte, or cr then lf, evicting the oldest line first whenever full
      ST_STORE: begin
        if (full) begin
          read_pos_next   = ltrb_pkg::pos_next(read_pos);
          byte_count_next = byte_count - ltrb_pkg::CNT_W'(1);
          seen_eol_next   = 1'b0;
          state_next      = ST_EV_RD;
        end else begin
          ram_wr_en       = 1'b1;
          write_pos_next  = ltrb_pkg::pos_next(write_pos);
          byte_count_next = byte_count + ltrb_pkg::CNT_W'(1);
          if (lf_follow) begin
            st_byte_next   = ltrb_pkg::CH_LF;
            lf_follow_next = 1'b0;
          end else begin
            state_next = ST_DONE;
          end
        end
      end

      ST_EV_RD: begin
        if (empty) begin
          state_next = ST_STORE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = read_pos;
          state_next  = ST_EV_CHK;
        end
      end

      // stop at the first ordinary byte after the cr/lf run
      ST_EV_CHK: begin
        if (!ram_eol && seen_eol) begin
          state_next = ST_STORE;
        end else begin
          if (ram_eol) begin
            seen_eol_next = 1'b1;
          end
          read_pos_next   = ltrb_pkg::pos_next(read_pos);
          byte_count_next = byte_count - ltrb_pkg::CNT_W'(1);
          state_next      = ST_EV_RD;
        end
      end

      ST_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = rd_idx;
        rd_ok_next  = off_in_range;
        state_next  = ST_RD_WAIT;
      end

      ST_RD_WAIT: begin
        rd_byte_next = ram_rd_data;
        state_next   = ST_DONE;
      end

      // hand the result over once the output register is free
      ST_DONE: begin
        if (!result_valid || result_ready) begin
          result_valid_next          = 1'b1;
          result_next.read_data      = rd_ok ? rd_byte : '0;
          result_next.read_valid     = rd_ok;
          result_next.oldest_pos     = ltrb_pkg::POS_W'(read_pos);
          result_next.next_write_pos = ltrb_pkg::POS_W'(write_pos);
          result_next.fill_count     = ltrb_pkg::FILL_W'(byte_count);
          state_next                 = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      read_pos     <= '0;
      write_pos    <= '0;
      byte_count   <= '0;
      cr_pending   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      read_pos     <= read_pos_next;
      write_pos    <= write_pos_next;
      byte_count   <= byte_count_next;
      cr_pending   <= cr_pending_next;
      result_valid <= result_valid_next;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    cur          <= cur_next;
    st_byte      <= st_byte_next;
    lf_follow    <= lf_follow_next;
    bu_then_proc <= bu_then_proc_next;
    seen_eol     <= seen_eol_next;
    rd_ok        <= rd_ok_next;
    rd_byte      <= rd_byte_next;
    result       <= result_next;
  end

  // write position should always sit fill count bytes past the oldest byte
  logic [ltrb_pkg::CNT_W:0]    wp_sum;
  logic [ltrb_pkg::ADDR_W-1:0] wp_expect;

  assign wp_sum    = (ltrb_pkg::CNT_W + 1)'(read_pos) + (ltrb_pkg::CNT_W + 1)'(byte_count);
  assign wp_expect = (wp_sum >= (ltrb_pkg::CNT_W + 1)'(ltrb_pkg::DEPTH))
                     ? ltrb_pkg::ADDR_W'(wp_sum - (ltrb_pkg::CNT_W + 1)'(ltrb_pkg::DEPTH))
                     : ltrb_pkg::ADDR_W'(wp_sum);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= ltrb_pkg::CNT_W'(ltrb_pkg::DEPTH))
    else $error("fill count above store depth");

  a_pos_consistent: assert property (@(posedge clk) disable iff (rst)
    write_pos == wp_expect)
    else $error("write position out of step with oldest position and fill count");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> !full)
    else $error("store written while full");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("second transaction accepted while busy");

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

  // cycles with no transaction on either side before the run is declared hung
  localparam int QUIET_LIMIT  = 60000;
  localparam int DRAIN_CYCLES = 50;
  localparam int TOTAL_ITEMS  = 1450;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_ready;
  ltrb_pkg::item_t   item         = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  ltrb_pkg::result_t result;

  line_evicting_text_ring_buffer u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // ring predictor: own copy of the text store, positions, fill and pending cr
  // ---------------------------------------------------------------------------
  logic [ltrb_pkg::BYTE_W-1:0] ring_text [ltrb_pkg::DEPTH];
  logic [ltrb_pkg::ADDR_W-1:0] ring_oldest  = '0;
  logic [ltrb_pkg::ADDR_W-1:0] ring_wr      = '0;
  logic [ltrb_pkg::FILL_W-1:0] ring_held    = '0;
  logic                        ring_cr_held = 1'b0;

  // status each accepted transaction should produce, oldest first
  ltrb_pkg::result_t ring_outcomes [$];
  int unsigned       mismatches = 0;
  int unsigned       items_sent = 0;

  // traffic shaping: no_gaps is shared by the sender and the receiver, the hold-off is the receiver's
  bit no_gaps         = 1'b0;
  int hold_off_cycles = 0;

  function automatic logic [ltrb_pkg::ADDR_W-1:0] ring_fwd(logic [ltrb_pkg::ADDR_W-1:0] p);
    return (int'(p) + 1 >= ltrb_pkg::DEPTH) ? '0 : ltrb_pkg::ADDR_W'(int'(p) + 1);
  endfunction

  function automatic logic [ltrb_pkg::ADDR_W-1:0] ring_back(logic [ltrb_pkg::ADDR_W-1:0] p);
    return (p == '0) ? ltrb_pkg::ADDR_W'(ltrb_pkg::DEPTH - 1)
                     : ltrb_pkg::ADDR_W'(int'(p) - 1);
  endfunction

  // oldest byte always goes, then the rest of its line and the eol run after it
  function automatic void drop_oldest_line();
    bit                          past_eol = 1'b0;
    logic [ltrb_pkg::BYTE_W-1:0] c;
    ring_oldest = ring_fwd(ring_oldest);
    ring_held--;
    while (ring_held > 0) begin
      c = ring_text[ring_oldest];
      if (c == ltrb_pkg::CH_CR || c == ltrb_pkg::CH_LF) begin
        past_eol = 1'b1;
      end else if (past_eol) begin
        break;
      end
      ring_oldest = ring_fwd(ring_oldest);
      ring_held--;
    end
  endfunction

  function automatic void push_byte(logic [ltrb_pkg::BYTE_W-1:0] c);
    if (ring_held >= ltrb_pkg::DEPTH) drop_oldest_line();
    ring_text[ring_wr] = c;
    ring_wr = ring_fwd(ring_wr);
    ring_held++;
  endfunction

  // step the write position back to just after the last lf, or to empty
  function automatic void rewind_line();
    while (ring_held > 0 && ring_text[ring_back(ring_wr)] != ltrb_pkg::CH_LF) begin
      ring_wr = ring_back(ring_wr);
      ring_held--;
    end
  endfunction

  function automatic void ring_append(logic [ltrb_pkg::BYTE_W-1:0] c, logic last);
    if (ring_cr_held) begin
      ring_cr_held = 1'b0;
      if (c == ltrb_pkg::CH_LF) begin
        push_byte(ltrb_pkg::CH_CR);
        push_byte(c);
        return;
      end
      rewind_line();
    end
    if (c == ltrb_pkg::CH_CR) begin
      if (last) rewind_line();
      else ring_cr_held = 1'b1;
    end else begin
      push_byte(c);
    end
  endfunction

  function automatic ltrb_pkg::result_t ring_step(ltrb_pkg::item_t it);
    ltrb_pkg::result_t r = '0;
    int unsigned       idx;
    case (it.func)
      ltrb_pkg::FUNC_APPEND: ring_append(it.char_in, it.last_of_string);
      ltrb_pkg::FUNC_READ: begin
        if (it.read_offset < ring_held) begin
          idx = ring_oldest + it.read_offset;
          if (idx >= ltrb_pkg::DEPTH) idx -= ltrb_pkg::DEPTH;
          r.read_data  = ring_text[ltrb_pkg::ADDR_W'(idx)];
          r.read_valid = 1'b1;
        end
      end
      ltrb_pkg::FUNC_CLEAR: begin
        ring_oldest  = '0;
        ring_wr      = '0;
        ring_held    = '0;
        ring_cr_held = 1'b0;
      end
      default: ;
    endcase
    r.oldest_pos     = ring_oldest;
    r.next_write_pos = ring_wr;
    r.fill_count     = ring_held;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: valid held with a stable payload until the block takes it
  // ---------------------------------------------------------------------------
  task automatic send_item(ltrb_pkg::item_t it);
    // random idle cycles between transactions, none during the steady stretch
    while (!no_gaps && $urandom_range(99) < 17) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    // inputs only move at the rising edge, so the falling edge sees settled values
    do @(negedge clk); while (!item_ready);
    ring_outcomes.push_back(ring_step(it));
    items_sent++;
    @(posedge clk);
  endtask

  function automatic ltrb_pkg::item_t make_item(ltrb_pkg::func_t f,
                                                logic [ltrb_pkg::BYTE_W-1:0] c,
                                                logic last,
                                                logic [ltrb_pkg::OFF_W-1:0] off);
    ltrb_pkg::item_t it;
    it.func           = f;
    it.char_in        = c;
    it.last_of_string = last;
    it.read_offset    = off;
    return it;
  endfunction

  // mostly printable text, sometimes any byte that is not a line end
  function automatic logic [ltrb_pkg::BYTE_W-1:0] text_char();
    logic [ltrb_pkg::BYTE_W-1:0] c;
    if ($urandom_range(99) < 80) return ltrb_pkg::BYTE_W'($urandom_range(8'h7e, 8'h20));
    do c = ltrb_pkg::BYTE_W'($urandom); while (c == ltrb_pkg::CH_CR || c == ltrb_pkg::CH_LF);
    return c;
  endfunction

  // inside the held bytes, around the fill edge, or anywhere
  function automatic logic [ltrb_pkg::OFF_W-1:0] pick_offset();
    int unsigned sel = $urandom_range(3);
    if (sel < 2 && ring_held > 0) return ltrb_pkg::OFF_W'($urandom_range(ring_held - 1));
    if (sel == 2) begin
      return ltrb_pkg::OFF_W'($urandom_range(ring_held + 2,
                                             (ring_held > 2) ? ring_held - 2 : 0));
    end
    return ltrb_pkg::OFF_W'($urandom);
  endfunction

  task automatic put_char(logic [ltrb_pkg::BYTE_W-1:0] c, logic last);
    send_item(make_item(ltrb_pkg::FUNC_APPEND, c, last, ltrb_pkg::OFF_W'($urandom)));
  endtask

  task automatic put_text(int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) put_char(text_char(), 1'b0);
  endtask

  task automatic read_at(logic [ltrb_pkg::OFF_W-1:0] off);
    send_item(make_item(ltrb_pkg::FUNC_READ, ltrb_pkg::BYTE_W'($urandom), 1'($urandom), off));
  endtask

  task automatic clear_ring();
    send_item(make_item(ltrb_pkg::FUNC_CLEAR, ltrb_pkg::BYTE_W'($urandom), 1'($urandom),
                        ltrb_pkg::OFF_W'($urandom)));
  endtask

  // ---------------------------------------------------------------------------
  // receiver and result checking
  // ---------------------------------------------------------------------------
  task automatic check_result(ltrb_pkg::result_t got);
    ltrb_pkg::result_t want;
    if (ring_outcomes.size() == 0) begin
      $error("result transaction with nothing expected: %h", got);
      mismatches++;
      return;
    end
    want = ring_outcomes.pop_front();
    if (got.read_data !== want.read_data) begin
      $error("read_data expected %0h actual %0h", want.read_data, got.read_data);
      mismatches++;
    end
    if (got.read_valid !== want.read_valid) begin
      $error("read_valid expected %0b actual %0b", want.read_valid, got.read_valid);
      mismatches++;
    end
    if (got.oldest_pos !== want.oldest_pos) begin
      $error("oldest_pos expected %0d actual %0d", want.oldest_pos, got.oldest_pos);
      mismatches++;
    end
    if (got.next_write_pos !== want.next_write_pos) begin
      $error("next_write_pos expected %0d actual %0d", want.next_write_pos,
             got.next_write_pos);
      mismatches++;
    end
    if (got.fill_count !== want.fill_count) begin
      $error("fill_count expected %0d actual %0d", want.fill_count, got.fill_count);
      mismatches++;
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      // a requested hold-off is counted down here, one cycle at a time
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= no_gaps || ($urandom_range(99) >= 17);
      end
      @(negedge clk);
      if (result_valid && result_ready) check_result(result);
    end
  end

  // hang detector: counts cycles in which neither side moves a transaction
  int unsigned quiet_cycles = 0;
  always @(negedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty reads, unused code, cr handling in all its forms, clear
  task automatic test_basics();
    read_at('0);
    read_at(ltrb_pkg::OFF_W'(ltrb_pkg::DEPTH - 1));
    send_item(make_item(ltrb_pkg::FUNC_NONE, ltrb_pkg::BYTE_W'($urandom), 1'($urandom),
                        ltrb_pkg::OFF_W'($urandom)));
    put_char("H", 1'b0);
    put_char("i", 1'b0);
    put_char(ltrb_pkg::CH_CR, 1'b0);  // held pending
    read_at(ltrb_pkg::OFF_W'(1));     // read sees the state with cr still pending
    put_char(ltrb_pkg::CH_LF, 1'b1);  // cr lf stored together
    put_char(8'h00, 1'b0);
    put_char(8'hff, 1'b1);
    put_char(ltrb_pkg::CH_CR, 1'b1);  // cr ending a string backs up at once
    put_char("a", 1'b0);
    put_char(ltrb_pkg::CH_CR, 1'b0);
    put_char("b", 1'b1);              // pending cr then plain byte: back up, then store
    put_char(ltrb_pkg::CH_CR, 1'b0);
    put_char(ltrb_pkg::CH_CR, 1'b1);  // pending cr resolved by another cr
    read_at(ltrb_pkg::OFF_W'(3));
    read_at(ltrb_pkg::OFF_W'(4));     // just past the held bytes
    read_at(ltrb_pkg::OFF_W'(ltrb_pkg::DEPTH - 1));
    put_char(ltrb_pkg::CH_CR, 1'b0);
    clear_ring();                     // drops the pending cr
    put_char(ltrb_pkg::CH_LF, 1'b1);  // so the lf goes in alone
    read_at('0);
    put_char("x", 1'b0);
    put_char(ltrb_pkg::CH_CR, 1'b1);
  endtask

  // whole lines with no idling; the receiver stalls long enough at the start
  // to back up the input
  task automatic test_lines_backpressure();
    int unsigned pushed = 0;
    int unsigned len;
    int unsigned ending;
    clear_ring();
    no_gaps         = 1'b1;
    hold_off_cycles = 300;
    while (pushed < 400) begin
      len = $urandom_range(70);
      put_text(len);
      ending = $urandom_range(9);
      if (ending < 5) begin
        put_char(ltrb_pkg::CH_CR, 1'b0);
        put_char(ltrb_pkg::CH_LF, 1'b1);
        pushed += len + 2;
      end else if (ending < 9) begin
        put_char(ltrb_pkg::CH_LF, 1'b1);
        pushed += len + 1;
      end else begin
        // blank line after the crlf
        put_char(ltrb_pkg::CH_CR, 1'b0);
        put_char(ltrb_pkg::CH_LF, 1'b0);
        put_char(ltrb_pkg::CH_LF, 1'b1);
        pushed += len + 3;
      end
      read_at(pick_offset());
    end
    no_gaps = 1'b0;
  endtask

  // a long run with no line end: a string ending in cr backs up to empty
  task automatic test_backup_unbroken();
    clear_ring();
    put_text(200);
    read_at(ltrb_pkg::OFF_W'(199));
    read_at('0);
    put_char(ltrb_pkg::CH_CR, 1'b1);
    read_at('0);
  endtask

  // mostly well-formed strings with random content, mixed with reads, noise,
  // unused codes and the odd clear, up to the item budget
  task automatic test_random_traffic();
    int unsigned                 pick;
    int unsigned                 len;
    int unsigned                 i;
    logic [ltrb_pkg::BYTE_W-1:0] c;
    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = $urandom_range(20);
        for (i = 0; i < len; i++) begin
          // a stray line end inside a string now and then
          if ($urandom_range(19) == 0) c = $urandom_range(1) ? ltrb_pkg::CH_CR : ltrb_pkg::CH_LF;
          else c = text_char();
          put_char(c, 1'b0);
        end
        case ($urandom_range(3))
          0: begin
            put_char(ltrb_pkg::CH_CR, 1'b0);
            if ($urandom_range(3) == 0) read_at(pick_offset());
            put_char(ltrb_pkg::CH_LF, 1'b1);
          end
          1: put_char(ltrb_pkg::CH_LF, 1'b1);
          2: put_char(ltrb_pkg::CH_CR, 1'b1);
          default: put_char(text_char(), 1'b1);
        endcase
      end else if (pick < 88) begin
        read_at(pick_offset());
      end else if (pick < 94) begin
        send_item(make_item(ltrb_pkg::FUNC_APPEND, ltrb_pkg::BYTE_W'($urandom), 1'($urandom),
                            ltrb_pkg::OFF_W'($urandom)));
      end else if (pick < 97) begin
        send_item(make_item(ltrb_pkg::FUNC_NONE, ltrb_pkg::BYTE_W'($urandom), 1'($urandom),
                            ltrb_pkg::OFF_W'($urandom)));
      end else if (pick < 98) begin
        clear_ring();
      end else begin
        send_item(make_item(ltrb_pkg::func_t'(2'($urandom_range(3))),
                            ltrb_pkg::BYTE_W'($urandom), 1'($urandom),
                            ltrb_pkg::OFF_W'($urandom)));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_basics();
    test_lines_backpressure();
    test_backup_unbroken();
    test_random_traffic();
    item_valid <= 1'b0;
    // drain: the hang detector covers results that never arrive
    while (ring_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
